// ===== src/cbfc_pkg.sv =====
package cbfc_pkg;

	// configuration register file
	localparam int NUM_REGS   = 8;
	localparam int REG_AW     = $clog2(NUM_REGS);
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;

	// matrix and input formats
	localparam int WORD_W      = 32;
	localparam int IN_W        = 12;
	localparam int NUM_ROWS    = 4;
	localparam int NUM_COLS    = 4;
	localparam int NUM_CORNERS = 8;
	localparam int NUM_PLANES  = 6;
	localparam int BOX_MARGIN  = 5;

	// clip rows
	localparam int ROW_X = 0;
	localparam int ROW_Y = 1;
	localparam int ROW_Z = 2;
	localparam int ROW_W = 3;

	// plane flags
	localparam int PL_LEFT   = 0;
	localparam int PL_RIGHT  = 1;
	localparam int PL_BOTTOM = 2;
	localparam int PL_TOP    = 3;
	localparam int PL_NEAR   = 4;
	localparam int PL_FAR    = 5;

	// m[row][col], each a Q16.16 word
	typedef logic [NUM_ROWS-1:0][NUM_COLS-1:0][WORD_W-1:0] mat_t;

	// signed width of a box coordinate: covers +-(2048*size + size + margin)
	function automatic int coord_w(input int cs);
		return IN_W + 1 + $clog2(cs + 1);
	endfunction

	// signed width of a clip component: three products and a translation plus headroom
	function automatic int acc_w(input int cs);
		return coord_w(cs) + WORD_W + 2;
	endfunction

endpackage

// ===== src/cbfc_cfg_regs.sv =====
module cbfc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [cbfc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cbfc_pkg::CFG_DATA_W-1:0]     cfg_data,
	output cbfc_pkg::mat_t                      mat
);
	import cbfc_pkg::*;

	logic [CFG_DATA_W-1:0] regs_q [NUM_REGS];

	// register write; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
			regs_q[cfg_index[REG_AW-1:0]] <= cfg_data;
		end
	end

	// unpack: register 2*row + col/2, low word = even column
	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				mat[r][c] = regs_q[r * 2 + c / 2][(c % 2) * WORD_W +: WORD_W];
			end
		end
	end

endmodule

// ===== src/cbfc_xform.sv =====
module cbfc_xform #(
	parameter int CHUNK_SIZE = 16,
	localparam int CW = cbfc_pkg::coord_w(CHUNK_SIZE),
	localparam int AW = cbfc_pkg::acc_w(CHUNK_SIZE)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [cbfc_pkg::IN_W-1:0]        chunk_x,
	input  logic [cbfc_pkg::IN_W-1:0]        chunk_z,
	input  cbfc_pkg::mat_t                   mat,
	output logic                             valid_s4,
	output logic signed [AW-1:0]             clip_s4 [cbfc_pkg::NUM_CORNERS][cbfc_pkg::NUM_ROWS]
);
	import cbfc_pkg::*;

	localparam int PW = WORD_W + CW;
	localparam logic signed [CW-1:0] SIZE_C   = CW'(CHUNK_SIZE);
	localparam logic signed [CW-1:0] MARGIN_C = CW'(BOX_MARGIN);

	logic                  valid_s1, valid_s2, valid_s3;
	logic signed [CW-1:0]  xs_s1 [2];
	logic signed [CW-1:0]  zs_s1 [2];
	logic signed [PW-1:0]  px_s2 [NUM_ROWS][2];
	logic signed [PW-1:0]  pz_s2 [NUM_ROWS][2];
	logic signed [PW-1:0]  py_s2 [NUM_ROWS];
	logic signed [WORD_W-1:0] m3_s2 [NUM_ROWS];
	logic signed [AW-1:0]  xz_s3 [NUM_ROWS][4];
	logic signed [AW-1:0]  y_s3  [NUM_ROWS][2];
	logic signed [CW-1:0]  cx_ext, cz_ext;

	assign cx_ext = CW'($signed(chunk_x));
	assign cz_ext = CW'($signed(chunk_z));

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// s1: box extents in x and z
	always_ff @(posedge clk) begin
		xs_s1[0] <= cx_ext * SIZE_C - MARGIN_C;
		xs_s1[1] <= cx_ext * SIZE_C + SIZE_C + MARGIN_C;
		zs_s1[0] <= cz_ext * SIZE_C - MARGIN_C;
		zs_s1[1] <= cz_ext * SIZE_C + SIZE_C + MARGIN_C;
	end

	// s2: column 0 and 2 products per x and z extent, column 1 times the box height, column 3 registered
	always_ff @(posedge clk) begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int i = 0; i < 2; i++) begin
				px_s2[r][i] <= PW'($signed(mat[r][0])) * PW'(xs_s1[i]);
				pz_s2[r][i] <= PW'($signed(mat[r][2])) * PW'(zs_s1[i]);
			end
			py_s2[r] <= PW'($signed(mat[r][1])) * PW'(SIZE_C);
			m3_s2[r] <= $signed(mat[r][3]);
		end
	end

	// s3: x+z partial sums and y+translation partial sums
	always_ff @(posedge clk) begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int j = 0; j < 4; j++) begin
				xz_s3[r][j] <= AW'(px_s2[r][j % 2]) + AW'(pz_s2[r][j / 2]);
			end
			y_s3[r][0] <= AW'(m3_s2[r]);
			y_s3[r][1] <= AW'(py_s2[r]) + AW'(m3_s2[r]);
		end
	end

	// s4: full clip vector per corner (bit0 x, bit1 z, bit2 y)
	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_CORNERS; k++) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				clip_s4[k][r] <= xz_s3[r][k % 4] + y_s3[r][k / 4];
			end
		end
	end

endmodule

// ===== src/cbfc_test.sv =====
module cbfc_test #(
	parameter int CHUNK_SIZE = 16,
	localparam int AW = cbfc_pkg::acc_w(CHUNK_SIZE)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s4,
	input  logic signed [AW-1:0]  clip_s4 [cbfc_pkg::NUM_CORNERS][cbfc_pkg::NUM_ROWS],
	output logic                  done,
	output logic                  visible
);
	import cbfc_pkg::*;

	logic                       valid_s5;
	logic [NUM_CORNERS-1:0]     wpos_s5;
	logic [NUM_PLANES-1:0]      out_s5 [NUM_CORNERS];
	logic                       all_wpos, culled;
	logic [NUM_PLANES-1:0]      plane_all;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
			done     <= valid_s5;
		end
	end

	// s5: per corner, w sign and outside flags for each plane
	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_CORNERS; k++) begin
			wpos_s5[k]           <= (clip_s4[k][ROW_W] > 0);
			out_s5[k][PL_LEFT]   <= (clip_s4[k][ROW_X] <= -clip_s4[k][ROW_W]);
			out_s5[k][PL_RIGHT]  <= (clip_s4[k][ROW_X] >= clip_s4[k][ROW_W]);
			out_s5[k][PL_BOTTOM] <= (clip_s4[k][ROW_Y] <= -clip_s4[k][ROW_W]);
			out_s5[k][PL_TOP]    <= (clip_s4[k][ROW_Y] >= clip_s4[k][ROW_W]);
			out_s5[k][PL_NEAR]   <= (clip_s4[k][ROW_Z] <= -clip_s4[k][ROW_W]);
			out_s5[k][PL_FAR]    <= (clip_s4[k][ROW_Z] >= clip_s4[k][ROW_W]);
		end
	end

	// reduce: hidden only if all w > 0 and one plane has every corner outside
	always_comb begin
		plane_all = '1;
		for (int k = 0; k < NUM_CORNERS; k++) begin
			plane_all = plane_all & out_s5[k];
		end
		all_wpos = &wpos_s5;
		culled   = |plane_all;
	end

	// s6: result register
	always_ff @(posedge clk) begin
		visible <= !(all_wpos && culled);
	end

endmodule

// ===== src/chunk_box_frustum_cull.sv =====
// Channel   Direction  Signals                                  Request taken when
// input     in         start, busy, chunk_x, chunk_z            start && !busy
// result    out        done, visible                            done (one cycle)
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// Six-stage pipeline: coordinates, products, partial sums, clip vectors,
// plane compares, reduction. One request per cycle, results in request order.
// busy is always low and the pipeline never stalls; the receiver takes every result.
// arst_n clears the matrix registers to zero and empties the pipeline.
// The matrix is read live by the product stage, so write it only while idle.
module chunk_box_frustum_cull #(
	parameter int CHUNK_SIZE = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [cbfc_pkg::IN_W-1:0]        chunk_x,
	input  logic [cbfc_pkg::IN_W-1:0]        chunk_z,
	output logic                             done,
	output logic                             visible,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cbfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cbfc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cbfc_pkg::*;

	localparam int AW = acc_w(CHUNK_SIZE);

	mat_t                 mat;
	logic                 in_valid;
	logic                 valid_s4;
	logic signed [AW-1:0] clip_s4 [NUM_CORNERS][NUM_ROWS];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign in_valid  = start && !busy;

	cbfc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mat       (mat)
	);

	cbfc_xform #(
		.CHUNK_SIZE (CHUNK_SIZE)
	) u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.chunk_x  (chunk_x),
		.chunk_z  (chunk_z),
		.mat      (mat),
		.valid_s4 (valid_s4),
		.clip_s4  (clip_s4)
	);

	cbfc_test #(
		.CHUNK_SIZE (CHUNK_SIZE)
	) u_test (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s4 (valid_s4),
		.clip_s4  (clip_s4),
		.done     (done),
		.visible  (visible)
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import cbfc_pkg::*;

	localparam int CHUNK_SIZE     = 16;
	localparam int LATENCY        = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_PHASES       = 8;
	localparam int PHASE_ITEMS    = 50;
	localparam int N_CFG_SLOTS    = 1 << CFG_IDX_W;

	// Q16.16 constants
	localparam logic [31:0] Q_ONE     = 32'h0001_0000;
	localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
	localparam logic [31:0] Q_FIVE    = 32'h0005_0000;
	localparam logic [31:0] Q_100     = 32'h0064_0000;
	localparam logic [31:0] Q_1000    = 32'h03E8_0000;

	// register indexes
	localparam int REG_R0_C01 = 0;
	localparam int REG_R0_C23 = 1;
	localparam int REG_R1_C01 = 2;
	localparam int REG_R1_C23 = 3;
	localparam int REG_R2_C01 = 4;
	localparam int REG_R2_C23 = 5;
	localparam int REG_R3_C01 = 6;
	localparam int REG_R3_C23 = 7;

	typedef logic [NUM_REGS-1:0][CFG_DATA_W-1:0] regfile_t;

	// hand-built matrices for the directed part
	typedef enum {
		DM_RESET,
		DM_UNIT,
		DM_EDGE_W,
		DM_BEHIND,
		DM_MIN,
		DM_MAX,
		DM_ONES
	} dm_set_e;

	// families of random matrices
	typedef enum {
		MX_RANDOM,
		MX_ORTHO,
		MX_PERSP,
		MX_FAR_W
	} mat_style_e;

	typedef struct {
		dm_set_e mset;
		int      cx;
		int      cz;
		bit      known;
		bit      vis;
	} dir_row_t;

	localparam int N_DIR = 25;

	// directed requests, grouped by matrix; known rows carry the answer
	dir_row_t dir_rows [N_DIR] = '{
		'{DM_RESET,      0,      0, 1'b1, 1'b1},
		'{DM_RESET,  -2048,  -2048, 1'b1, 1'b1},
		'{DM_RESET,   2047,   2047, 1'b1, 1'b1},
		'{DM_RESET,  -2048,   2047, 1'b1, 1'b1},
		'{DM_RESET,   2047,  -2048, 1'b1, 1'b1},
		'{DM_UNIT,       0,      0, 1'b1, 1'b1},
		'{DM_UNIT,      62,      0, 1'b1, 1'b1},
		'{DM_UNIT,      63,      0, 1'b1, 1'b0},
		'{DM_UNIT,     100,      0, 1'b1, 1'b0},
		'{DM_UNIT,    -100,      0, 1'b1, 1'b0},
		'{DM_UNIT,       0,    100, 1'b1, 1'b0},
		'{DM_UNIT,       0,   -100, 1'b1, 1'b0},
		'{DM_UNIT,    2047,   2047, 1'b1, 1'b0},
		'{DM_UNIT,   -2048,  -2048, 1'b1, 1'b0},
		'{DM_EDGE_W,     0,      0, 1'b1, 1'b1},
		'{DM_EDGE_W,     1,      0, 1'b1, 1'b0},
		'{DM_EDGE_W,    -1,      0, 1'b1, 1'b1},
		'{DM_EDGE_W,     5,     -3, 1'b0, 1'b0},
		'{DM_BEHIND,   100,      0, 1'b1, 1'b1},
		'{DM_BEHIND,  2047,  -2048, 1'b1, 1'b1},
		'{DM_MIN,        0,      0, 1'b0, 1'b0},
		'{DM_MIN,     2047,   2047, 1'b0, 1'b0},
		'{DM_MIN,    -2048,  -2048, 1'b0, 1'b0},
		'{DM_MAX,        1,     -1, 1'b0, 1'b0},
		'{DM_ONES,   -2048,   2047, 1'b0, 1'b0}
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic [IN_W-1:0]       chunk_x   = '0;
	logic [IN_W-1:0]       chunk_z   = '0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  busy;
	logic                  done;
	logic                  visible;
	logic                  cfg_ready;

	regfile_t matrix_regs = '0;
	bit       visible_expected_q [$];
	int       idle_pct      = 0;
	int       n_errors      = 0;
	int       n_requests    = 0;
	int       n_results     = 0;
	int       n_culled      = 0;
	int       n_loads       = 0;
	int       stall_cycles  = 0;

	chunk_box_frustum_cull #(
		.CHUNK_SIZE(CHUNK_SIZE)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.chunk_x   (chunk_x),
		.chunk_z   (chunk_z),
		.done      (done),
		.visible   (visible),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// signed Q16.16 entry m[row][col] out of the register image
	function automatic longint mat_entry(regfile_t m, int row, int col);
		logic [CFG_DATA_W-1:0] r;
		logic signed [WORD_W-1:0] e;
		r = m[row * 2 + col / 2];
		e = col[0] ? r[63:32] : r[31:0];
		return longint'(e);
	endfunction

	function automatic longint clip_comp(regfile_t m, int row, longint px, longint py,
			longint pz);
		return mat_entry(m, row, 0) * px + mat_entry(m, row, 1) * py
			+ mat_entry(m, row, 2) * pz + mat_entry(m, row, 3);
	endfunction

	// padded chunk box against the six clip planes
	function automatic bit predict_visible(regfile_t m, logic [IN_W-1:0] cx_b,
			logic [IN_W-1:0] cz_b);
		longint cx, cz, px, py, pz, cw, vx, vy, vz;
		longint xs [2];
		longint zs [2];
		bit [NUM_PLANES-1:0] all_out;
		cx = longint'($signed(cx_b));
		cz = longint'($signed(cz_b));
		xs[0] = cx * CHUNK_SIZE - BOX_MARGIN;
		xs[1] = cx * CHUNK_SIZE + CHUNK_SIZE + BOX_MARGIN;
		zs[0] = cz * CHUNK_SIZE - BOX_MARGIN;
		zs[1] = cz * CHUNK_SIZE + CHUNK_SIZE + BOX_MARGIN;
		all_out = '1;
		for (int k = 0; k < NUM_CORNERS; k++) begin
			px = xs[k & 1];
			pz = zs[(k >> 1) & 1];
			py = (k & 4) ? CHUNK_SIZE : 0;
			cw = clip_comp(m, ROW_W, px, py, pz);
			// corner on or behind the eye plane: keep the chunk
			if (cw <= 0)
				return 1'b1;
			vx = clip_comp(m, ROW_X, px, py, pz);
			vy = clip_comp(m, ROW_Y, px, py, pz);
			vz = clip_comp(m, ROW_Z, px, py, pz);
			if (vx > -cw) all_out[PL_LEFT]   = 1'b0;
			if (vx < cw)  all_out[PL_RIGHT]  = 1'b0;
			if (vy > -cw) all_out[PL_BOTTOM] = 1'b0;
			if (vy < cw)  all_out[PL_TOP]    = 1'b0;
			if (vz > -cw) all_out[PL_NEAR]   = 1'b0;
			if (vz < cw)  all_out[PL_FAR]    = 1'b0;
		end
		return all_out == '0;
	endfunction

	function automatic regfile_t dir_matrix(dm_set_e s);
		regfile_t m;
		m = '0;
		case (s)
			DM_RESET: m = '0;
			DM_MIN:   m = {NUM_REGS{64'h8000_0000_8000_0000}};
			DM_MAX:   m = {NUM_REGS{64'h7FFF_FFFF_7FFF_FFFF}};
			DM_ONES:  m = '1;
			default: begin
				// x = px, y = py, z = pz, w set per case
				m[REG_R0_C01] = {32'h0, Q_ONE};
				m[REG_R1_C01] = {Q_ONE, 32'h0};
				m[REG_R2_C23] = {32'h0, Q_ONE};
				if (s == DM_UNIT) begin
					m[REG_R3_C23] = {Q_1000, 32'h0};
				end else if (s == DM_BEHIND) begin
					m[REG_R3_C23] = {Q_NEG_ONE, 32'h0};
				end else begin
					// x = px + 100 is right of w = px + 5 unless w <= 0
					m[REG_R0_C23] = {Q_100, 32'h0};
					m[REG_R3_C01] = {32'h0, Q_ONE};
					m[REG_R3_C23] = {Q_FIVE, 32'h0};
				end
			end
		endcase
		return m;
	endfunction

	function automatic logic [31:0] rand_q(int span);
		return 32'(int'($urandom_range(2 * span)) - span);
	endfunction

	function automatic regfile_t rand_matrix(mat_style_e sty);
		logic [31:0] e [NUM_ROWS][NUM_COLS];
		regfile_t m;
		for (int r = 0; r < NUM_ROWS; r++)
			for (int c = 0; c < NUM_COLS; c++)
				e[r][c] = $urandom;
		case (sty)
			MX_ORTHO: begin
				// constant positive w, small linear rows
				for (int r = 0; r < ROW_W; r++) begin
					for (int c = 0; c < 3; c++)
						e[r][c] = rand_q(1 << 17);
					e[r][3] = rand_q(1 << 28);
				end
				e[ROW_W] = '{32'h0, 32'h0, 32'h0, 32'($urandom_range(1 << 28, 1 << 16))};
			end
			MX_PERSP: begin
				// w follows depth, so it changes sign across the grid
				for (int r = 0; r < ROW_W; r++) begin
					for (int c = 0; c < 3; c++)
						e[r][c] = rand_q(1 << 17);
					e[r][3] = rand_q(1 << 28);
				end
				e[ROW_W] = '{32'h0, 32'h0, ($urandom_range(1) ? Q_ONE : Q_NEG_ONE),
					rand_q(1 << 26)};
			end
			MX_FAR_W: begin
				// w always positive, full-range plane rows
				for (int c = 0; c < 3; c++)
					e[ROW_W][c] = rand_q(1 << 10);
				e[ROW_W][3] = 32'h4000_0000 | 32'($urandom_range(1 << 20));
			end
			default: ;
		endcase
		for (int r = 0; r < NUM_ROWS; r++)
			for (int c = 0; c < NUM_COLS; c++)
				m[r * 2 + c / 2][(c % 2) * 32 +: 32] = e[r][c];
		return m;
	endfunction

	function automatic logic [IN_W-1:0] rand_coord();
		case ($urandom_range(3))
			0:       return IN_W'($urandom);
			1, 2:    return IN_W'(int'($urandom_range(127)) - 64);
			default: return $urandom_range(1) ? IN_W'(2040 + int'($urandom_range(7)))
				: IN_W'(-2048 + int'($urandom_range(7)));
		endcase
	endfunction

	task automatic report_mismatch(string what);
		n_errors++;
		$display("[%0t] MISMATCH %s", $time, what);
	endtask

	// one request; start stays high unless an idle gap follows
	task automatic send_chunk(logic [IN_W-1:0] cx, logic [IN_W-1:0] cz, bit known,
			bit vis);
		bit want;
		start   <= 1'b1;
		chunk_x <= cx;
		chunk_z <= cz;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		want = known ? vis : predict_visible(matrix_regs, cx, cz);
		visible_expected_q = {visible_expected_q, want};
		n_requests++;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// hold requests until every result is back
	task automatic drain();
		start <= 1'b0;
		while (visible_expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx < NUM_REGS)
			matrix_regs[idx] = val;
	endtask

	// all eight registers, then junk to the unused indexes
	task automatic load_matrix(regfile_t m);
		for (int i = 0; i < N_CFG_SLOTS; i++)
			write_reg(i, (i < NUM_REGS) ? m[i] : {$urandom, $urandom});
		cfg_valid <= 1'b0;
		n_loads++;
	endtask

	// result check
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (visible_expected_q.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, visible=%b", visible));
			end else begin
				n_results++;
				if (!visible_expected_q[0])
					n_culled++;
				if (visible !== visible_expected_q[0])
					report_mismatch($sformatf("result %0d: visible=%b, want %b",
						n_results, visible, visible_expected_q[0]));
				void'(visible_expected_q.pop_front());
			end
		end
	end

	// cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		dm_set_e cur_set;
		cur_set = DM_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < N_DIR; i++) begin
			if (dir_rows[i].mset != cur_set) begin
				drain();
				load_matrix(dir_matrix(dir_rows[i].mset));
				cur_set = dir_rows[i].mset;
			end
			send_chunk(IN_W'(dir_rows[i].cx), IN_W'(dir_rows[i].cz), dir_rows[i].known,
				dir_rows[i].vis);
		end

		// random phases: new matrix and sender idle rate each phase
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			load_matrix(rand_matrix(mat_style_e'(ph % 4)));
			idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 61 : 38;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_chunk(rand_coord(), rand_coord(), 1'b0, 1'b0);
		end

		drain();
		repeat (LATENCY + 4) @(posedge clk);

		$display("covered %0d chunk tests over %0d matrix loads, sender idle 0/38/61 pct",
			n_requests, n_loads);
		$display("results checked: %0d, of which %0d culled; %0d mismatches",
			n_results, n_culled, n_errors);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
